// File: design/fodt_pkg.sv
// Package with shared constants, request codes and chain control types for the dedup table.
`default_nettype none
package fodt_pkg;

  localparam int CAPACITY    = 64;
  localparam int KEY_WIDTH   = 64;
  localparam int IN_KEY_W    = 64;
  localparam int REQ_W       = 2;
  localparam int ENTRY_IDX_W = 6;
  localparam int RES_IDX_W   = 7;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH  = 2'd0,
    REQ_FIND  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef logic [KEY_WIDTH-1:0] key_t;

  typedef struct packed {
    logic             launch;
    logic             stop;
    logic             wr_en;
    logic [IDX_W-1:0] wr_sel;
    key_t             probe;
  } chain_ctl_t;

endpackage
`default_nettype wire

// File: design/fodt_cell.sv
// One table cell: holds a stored key and compares it when the search token passes through.
`default_nettype none
module fodt_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          token_in,
  input  wire logic          stop,
  input  wire logic          wr_en,
  input  wire fodt_pkg::key_t probe,
  output logic               token_out,
  output logic               match
);

  fodt_pkg::key_t key_r;
  logic           token_r;
  logic           token_nxt;

  assign token_nxt = token_in & ~stop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_r <= 1'b0;
    end else begin
      token_r <= token_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_r <= probe;
    end
  end

  assign token_out = token_r;
  assign match     = token_r & (key_r == probe);

endmodule
`default_nettype wire

// File: design/fodt_chain.sv
// Row of compare cells through which the search token moves one cell per cycle.
`default_nettype none
module fodt_chain (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire fodt_pkg::chain_ctl_t ctl,
  output logic                      hit
);

  logic [fodt_pkg::CAPACITY-1:0] tok;
  logic [fodt_pkg::CAPACITY-1:0] match_vec;

  for (genvar i = 0; i < fodt_pkg::CAPACITY; i++) begin : g_cell
    logic tin;
    logic wen;
    if (i == 0) begin : g_head
      assign tin = ctl.launch;
    end else begin : g_body
      assign tin = tok[i-1];
    end
    assign wen = ctl.wr_en && (ctl.wr_sel == fodt_pkg::IDX_W'(i));
    fodt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .token_in  (tin),
      .stop      (ctl.stop),
      .wr_en     (wen),
      .probe     (ctl.probe),
      .token_out (tok[i]),
      .match     (match_vec[i])
    );
  end

  assign hit = |match_vec;

  a_token_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok))
    else $error("more than one search token in the chain");

  a_hit_needs_token: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> (tok != '0))
    else $error("match reported without a search token");

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.stop && !ctl.launch |=> (tok == '0))
    else $error("search token survived a stop");

endmodule
`default_nettype wire

// File: design/find_or_insert_dedup_table_core.sv
// Top level of the find-or-insert dedup table: request control, entry memory and compare chain.
//
// Usage: requests enter on the in_ channel (valid/stall); a transaction is taken at a rising
// edge with in_valid high and in_stall low. Each request gives exactly one result
// transaction on the out_ channel, in request order. Push and find walk a search token
// through a row of compare cells, one cell per cycle, stopping at the first match or at
// the last stored entry. A push request that misses appends the key at the entry count
// unless the table is full, which flags overflow. Read returns the stored key from the
// entry memory; clear sets the entry count to zero. Timing: the block handles one request
// at a time. For push and find the walk along the cell row sets the time from acceptance
// to result; it runs to the matching index on a hit or over the stored entries on a miss.
// Read passes through the registered memory read. The next request is accepted once the
// result is in the output register, also while that result waits.
// Reset empties the table (entry count zero) and drops any pending result; stored keys
// are not erased. While out_stall is high the result holds and a completed later result
// waits inside until the output register is free.
`default_nettype none
module find_or_insert_dedup_table_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [fodt_pkg::REQ_W-1:0]         in_req_type,
  input  wire logic [fodt_pkg::IN_KEY_W-1:0]      in_key,
  input  wire logic [fodt_pkg::ENTRY_IDX_W-1:0]   in_entry_index,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [fodt_pkg::RES_IDX_W-1:0]          out_result_index,
  output logic                                    out_found,
  output logic [fodt_pkg::IN_KEY_W-1:0]           out_read_value,
  output logic [fodt_pkg::RES_IDX_W-1:0]          out_entry_count,
  output logic                                    out_overflow
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_READ,
    ST_FINISH
  } state_t;

  state_t                         state_r;
  fodt_pkg::req_t                 req_r;
  fodt_pkg::key_t                 probe_r;
  logic [fodt_pkg::IDX_W-1:0]     pos_r;
  logic [fodt_pkg::CNT_W-1:0]     count_r;
  logic [fodt_pkg::CNT_W-1:0]     res_idx_r;
  logic                           res_found_r;
  fodt_pkg::key_t                 res_val_r;
  logic                           res_ovf_r;
  logic                           out_valid_r;
  logic [fodt_pkg::RES_IDX_W-1:0] out_result_index_r;
  logic                           out_found_r;
  logic [fodt_pkg::IN_KEY_W-1:0]  out_read_value_r;
  logic [fodt_pkg::RES_IDX_W-1:0] out_entry_count_r;
  logic                           out_overflow_r;

  fodt_pkg::key_t                 mem [fodt_pkg::CAPACITY];
  fodt_pkg::key_t                 rd_q;

  fodt_pkg::req_t                 in_req;
  fodt_pkg::chain_ctl_t           ctl;
  logic                           in_accept;
  logic                           out_free;
  logic                           hit;
  logic                           last_pos;
  logic                           search_done;
  logic                           full;
  logic                           ins_en;

  assign in_req    = fodt_pkg::req_t'(in_req_type);
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign full        = (count_r == fodt_pkg::CNT_W'(fodt_pkg::CAPACITY));
  assign last_pos    = (fodt_pkg::CNT_W'(pos_r) + fodt_pkg::CNT_W'(1)) == count_r;
  assign search_done = (state_r == ST_SEARCH) && (hit || (count_r == '0) || last_pos);
  assign ins_en      = search_done && !hit && (req_r == fodt_pkg::REQ_PUSH) && !full;

  always_comb begin
    ctl        = '0;
    ctl.launch = in_accept && (count_r != '0) &&
                 ((in_req == fodt_pkg::REQ_PUSH) || (in_req == fodt_pkg::REQ_FIND));
    ctl.stop   = search_done;
    ctl.wr_en  = ins_en;
    ctl.wr_sel = count_r[fodt_pkg::IDX_W-1:0];
    ctl.probe  = (state_r == ST_IDLE) ? in_key[fodt_pkg::KEY_WIDTH-1:0] : probe_r;
  end

  fodt_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .hit   (hit)
  );

  always_ff @(posedge clk) begin
    if (ins_en) begin
      mem[count_r[fodt_pkg::IDX_W-1:0]] <= probe_r;
    end
    rd_q <= mem[in_entry_index];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            req_r       <= in_req;
            probe_r     <= in_key[fodt_pkg::KEY_WIDTH-1:0];
            pos_r       <= '0;
            res_idx_r   <= '0;
            res_found_r <= 1'b0;
            res_val_r   <= '0;
            res_ovf_r   <= 1'b0;
            unique case (in_req) inside
              fodt_pkg::REQ_PUSH, fodt_pkg::REQ_FIND: state_r <= ST_SEARCH;
              fodt_pkg::REQ_READ:                     state_r <= ST_READ;
              fodt_pkg::REQ_CLEAR: begin
                count_r <= '0;
                state_r <= ST_FINISH;
              end
              default:                                state_r <= ST_FINISH;
            endcase
          end
        end
        ST_SEARCH: begin
          if (search_done) begin
            res_val_r <= '0;
            state_r   <= ST_FINISH;
            if (hit) begin
              res_idx_r   <= fodt_pkg::CNT_W'(pos_r);
              res_found_r <= 1'b1;
              res_ovf_r   <= 1'b0;
            end else begin
              res_idx_r   <= count_r;
              res_found_r <= 1'b0;
              res_ovf_r   <= (req_r == fodt_pkg::REQ_PUSH) && full;
              if (ins_en) begin
                count_r <= count_r + fodt_pkg::CNT_W'(1);
              end
            end
          end else begin
            pos_r <= pos_r + fodt_pkg::IDX_W'(1);
          end
        end
        ST_READ: begin
          res_val_r <= rd_q;
          state_r   <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_r        <= 1'b1;
            out_result_index_r <= fodt_pkg::RES_IDX_W'(res_idx_r);
            out_found_r        <= res_found_r;
            out_read_value_r   <= fodt_pkg::IN_KEY_W'(res_val_r);
            out_entry_count_r  <= fodt_pkg::RES_IDX_W'(count_r);
            out_overflow_r     <= res_ovf_r;
            state_r            <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = out_result_index_r;
  assign out_found        = out_found_r;
  assign out_read_value   = out_read_value_r;
  assign out_entry_count  = out_entry_count_r;
  assign out_overflow     = out_overflow_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= fodt_pkg::CNT_W'(fodt_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_search_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) && (count_r != '0) |-> (fodt_pkg::CNT_W'(pos_r) < count_r))
    else $error("search position beyond stored entries");

  a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
    ins_en |=> (count_r == $past(count_r) + fodt_pkg::CNT_W'(1)))
    else $error("insert did not grow the entry count");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_overflow_r |->
      (out_entry_count_r == fodt_pkg::RES_IDX_W'(fodt_pkg::CAPACITY)))
    else $error("overflow reported on a table that is not full");

  a_found_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_found_r |-> (out_result_index_r < out_entry_count_r))
    else $error("found index not below entry count");

endmodule
`default_nettype wire
